/* hdl/lts_pkg.sv */
// shared types and constants for the lru tag store
`timescale 1ns / 1ps

package lts_pkg;

  // fixed field widths of the request and result ports
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned STAMP_W  = 64;

  // slot index width able to hold the largest supported store
  localparam int unsigned MAX_IDX_W = 6;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUT    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HIT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FILLED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PUT_OLD = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PUT_NEW = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TICK    = 3'd5;

  // outcome of one scan over the store
  typedef struct packed {
    logic                 match_found;
    logic [MAX_IDX_W-1:0] match_idx;
    logic [MAX_IDX_W-1:0] victim_idx;
    logic                 victim_used;
  } scan_res_t;

endpackage

/* hdl/lts_scan_unit.sv */
// compare unit folding one entry per enabled cycle into match and victim results
`timescale 1ns / 1ps

module lts_scan_unit #(
  parameter int unsigned KEY_BITS = 64,
  parameter int unsigned IDX_W    = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic                          en_i,
  input  logic                          elem_valid_i,
  input  logic [KEY_BITS-1:0]           elem_tag_i,
  input  logic [lts_pkg::STAMP_W-1:0]   elem_stamp_i,
  input  logic [IDX_W-1:0]              elem_idx_i,
  input  logic [KEY_BITS-1:0]           key_i,
  output lts_pkg::scan_res_t            res_o
);
  import lts_pkg::*;

  logic                 match_found_q, match_found_d;
  logic [MAX_IDX_W-1:0] match_idx_q, match_idx_d;
  logic                 inv_found_q, inv_found_d;
  logic [MAX_IDX_W-1:0] inv_idx_q, inv_idx_d;
  logic [STAMP_W-1:0]   best_stamp_q, best_stamp_d;
  logic [MAX_IDX_W-1:0] best_idx_q, best_idx_d;
  logic [MAX_IDX_W-1:0] idx_ext;

  assign idx_ext = MAX_IDX_W'(elem_idx_i);

  always_comb begin
    match_found_d = match_found_q;
    match_idx_d   = match_idx_q;
    inv_found_d   = inv_found_q;
    inv_idx_d     = inv_idx_q;
    best_stamp_d  = best_stamp_q;
    best_idx_d    = best_idx_q;
    if (clear_i) begin
      match_found_d = 1'b0;
      match_idx_d   = '0;
      inv_found_d   = 1'b0;
      inv_idx_d     = '0;
      best_stamp_d  = '1;
      best_idx_d    = '0;
    end else if (en_i) begin
      // first valid match wins
      if (elem_valid_i && !match_found_q && (elem_tag_i == key_i)) begin
        match_found_d = 1'b1;
        match_idx_d   = idx_ext;
      end
      // first free slot
      if (!elem_valid_i && !inv_found_q) begin
        inv_found_d = 1'b1;
        inv_idx_d   = idx_ext;
      end
      // oldest stamp, strict compare keeps the lowest index on ties
      if (elem_valid_i && (elem_stamp_i < best_stamp_q)) begin
        best_stamp_d = elem_stamp_i;
        best_idx_d   = idx_ext;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_found_q <= 1'b0;
      inv_found_q   <= 1'b0;
    end else begin
      match_found_q <= match_found_d;
      inv_found_q   <= inv_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_idx_q  <= match_idx_d;
    inv_idx_q    <= inv_idx_d;
    best_stamp_q <= best_stamp_d;
    best_idx_q   <= best_idx_d;
  end

  assign res_o.match_found = match_found_q;
  assign res_o.match_idx   = match_idx_q;
  assign res_o.victim_idx  = inv_found_q ? inv_idx_q : best_idx_q;
  assign res_o.victim_used = !inv_found_q;

endmodule

/* hdl/lru_tag_store.sv */
// top level of the fully associative lru tag store
`timescale 1ns / 1ps

// fully associative tag store with timestamp lru replacement
// - request channel (in_valid_i / in_ready_o): req_type_i, key_hash_i, fill_ok_i
//   lookup, put or tick; only the low KEY_BITS of the key are stored and compared
// - result channel (out_valid_o / out_ready_i): status_o, slot_o, evicted_o,
//   occupied_o, exactly one result per request
// - lookup and put walk every slot through one tag/stamp compare unit, one slot
//   per cycle from a single read port, then pass through the drain, decide and
//   done states; a new request is taken only once the previous result has been
//   loaded into the result register and the sequencer is back in idle
// - tick and the unused request type skip the scan and go straight from idle to
//   the done state
// - reset clears the valid bits, the occupancy count and the tick counter; the
//   tag and stamp arrays are left as they are and only read behind a valid bit
// - a stalled receiver holds the result register; one further request may be
//   accepted and scanned meanwhile, and it waits in its last step until the
//   result register frees up
module lru_tag_store #(
  parameter int unsigned ENTRIES  = 24,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lts_pkg::REQ_W-1:0]      req_type_i,
  input  logic [lts_pkg::KEY_W-1:0]      key_hash_i,
  input  logic                           fill_ok_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lts_pkg::STATUS_W-1:0]   status_o,
  output logic [lts_pkg::SLOT_W-1:0]     slot_o,
  output logic                           evicted_o,
  output logic [lts_pkg::OCC_W-1:0]      occupied_o
);
  import lts_pkg::*;

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned OCC_CW = $clog2(ENTRIES + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]           state_q, state_d;

  // latched request
  logic [REQ_W-1:0]     req_q;
  logic [KEY_BITS-1:0]  key_q;
  logic                 fill_q;

  // store state
  logic [KEY_BITS-1:0]  tag_mem   [ENTRIES];
  logic [STAMP_W-1:0]   stamp_mem [ENTRIES];
  logic [ENTRIES-1:0]   valid_q, valid_d;
  logic [OCC_CW-1:0]    occ_q, occ_d;
  logic [STAMP_W-1:0]   tick_q, tick_d;

  // scan read path
  logic [IDX_W-1:0]     addr_q, addr_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]     rd_idx_q;
  logic [KEY_BITS-1:0]  tag_rd_q;
  logic [STAMP_W-1:0]   stamp_rd_q;
  logic                 vld_rd_q;

  // write port
  logic                 tag_we, stamp_we;
  logic [IDX_W-1:0]     wr_idx;

  // result staging and output register
  logic [STATUS_W-1:0]  res_status_q, res_status_d;
  logic [SLOT_W-1:0]    res_slot_q, res_slot_d;
  logic                 res_evict_q, res_evict_d;
  logic                 out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]  status_q;
  logic [SLOT_W-1:0]    slot_q;
  logic                 evicted_q;
  logic [OCC_W-1:0]     occupied_q;
  logic                 out_load;

  logic                 in_fire;
  logic                 scan_clear;
  scan_res_t            scan_res;
  logic                 match;
  logic                 install;
  logic [IDX_W-1:0]     match_idx;
  logic [IDX_W-1:0]     victim_idx;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign scan_clear = in_fire;

  assign match      = scan_res.match_found;
  assign match_idx  = scan_res.match_idx[IDX_W-1:0];
  assign victim_idx = scan_res.victim_idx[IDX_W-1:0];

  // lookup installs only on a filled miss, put always installs
  assign install = (state_q == S_DECIDE) &&
                   (((req_q == REQ_LOOKUP) && !match && fill_q) || (req_q == REQ_PUT));
  assign wr_idx   = match ? match_idx : victim_idx;
  assign tag_we   = install;
  assign stamp_we = install || ((state_q == S_DECIDE) && (req_q == REQ_LOOKUP) && match);

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // shared compare unit, fed one slot per cycle
  lts_scan_unit #(
    .KEY_BITS (KEY_BITS),
    .IDX_W    (IDX_W)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (scan_clear),
    .en_i         (rd_vld_q),
    .elem_valid_i (vld_rd_q),
    .elem_tag_i   (tag_rd_q),
    .elem_stamp_i (stamp_rd_q),
    .elem_idx_i   (rd_idx_q),
    .key_i        (key_q),
    .res_o        (scan_res)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    rd_vld_d     = 1'b0;
    tick_d       = tick_q;
    valid_d      = valid_q;
    occ_d        = occ_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_evict_d  = res_evict_q;
    out_valid_d  = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_slot_d  = '0;
          res_evict_d = 1'b0;
          addr_d      = '0;
          case (req_type_i) inside
            REQ_LOOKUP, REQ_PUT: begin
              state_d = S_SCAN;
            end
            REQ_TICK: begin
              tick_d       = tick_q + STAMP_W'(1);
              res_status_d = ST_TICK;
              state_d      = S_DONE;
            end
            default: begin
              // unused request type: nothing changes
              res_status_d = ST_MISS;
              state_d      = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        rd_vld_d = 1'b1;
        if (addr_q == IDX_W'(ENTRIES - 1)) begin
          state_d = S_DRAIN;
        end else begin
          addr_d = addr_q + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        // last slot folds into the compare unit here
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (install) begin
          valid_d[wr_idx] = 1'b1;
          if (!match && !scan_res.victim_used) begin
            occ_d = occ_q + OCC_CW'(1);
          end
        end
        res_evict_d = install && !match && scan_res.victim_used;
        res_slot_d  = '0;
        if (req_q == REQ_LOOKUP) begin
          if (match) begin
            res_status_d = ST_HIT;
            res_slot_d   = SLOT_W'(match_idx);
          end else if (fill_q) begin
            res_status_d = ST_FILLED;
            res_slot_d   = SLOT_W'(victim_idx);
          end else begin
            res_status_d = ST_MISS;
          end
        end else begin
          res_status_d = match ? ST_PUT_OLD : ST_PUT_NEW;
          res_slot_d   = SLOT_W'(wr_idx);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      tick_q      <= '0;
      valid_q     <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      rd_vld_q    <= rd_vld_d;
      tick_q      <= tick_d;
      valid_q     <= valid_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request latch, result staging and output payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q  <= req_type_i;
      key_q  <= key_hash_i[KEY_BITS-1:0];
      fill_q <= fill_ok_i;
    end
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_evict_q  <= res_evict_d;
    if (out_load) begin
      status_q   <= res_status_q;
      slot_q     <= res_slot_q;
      evicted_q  <= res_evict_q;
      occupied_q <= OCC_W'(occ_q);
    end
  end

  // tag and stamp arrays: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[wr_idx] <= key_q;
    end
    if (stamp_we) begin
      stamp_mem[wr_idx] <= tick_q;
    end
    tag_rd_q   <= tag_mem[addr_q];
    stamp_rd_q <= stamp_mem[addr_q];
    vld_rd_q   <= valid_q[addr_q];
    rd_idx_q   <= addr_q;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign evicted_o   = evicted_q;
  assign occupied_o  = occupied_q;

  // occupancy count tracks the valid bits
  a_occ_matches_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == OCC_CW'($countones(valid_q)))
    else $error("occupancy count out of step with valid bits");

  // a hit always points at a valid slot
  a_match_is_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE) && match |-> valid_q[match_idx])
    else $error("scan match on an invalid slot");

  // eviction only happens when the store is full
  a_evict_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    install && !match && scan_res.victim_used |-> occ_q == OCC_CW'(ENTRIES))
    else $error("valid entry displaced while free slots remain");

  // a finished result is not dropped while the receiver stalls
  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(status_q))
    else $error("pending result lost under stall");

endmodule

/* dv/lru_tag_store_test.sv */
// self-checking testbench for the lru tag store, with a scoreboard class and random traffic
`timescale 1ns / 1ps

module lru_tag_store_test;
  import lts_pkg::*;

  localparam int unsigned ENTRIES  = 24;
  localparam int unsigned KEY_BITS = 64;

  // request type 3 has no meaning; the block answers it without touching state
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int unsigned RANDOM_REQUESTS = 1800;
  localparam int unsigned KEY_POOL_SIZE   = 40;
  localparam int unsigned IDLE_PERCENT    = 37;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned DRAIN_CYCLES    = 40;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                evicted;
    logic [OCC_W-1:0]    occupied;
  } result_t;

  // mirror of the tag store: predicts one result per accepted request and
  // holds it until the matching result comes out
  class lru_scoreboard;
    logic [KEY_BITS-1:0] tags[ENTRIES];
    logic [STAMP_W-1:0]  stamps[ENTRIES];
    bit                  live[ENTRIES];
    logic [STAMP_W-1:0]  now_tick;
    result_t             expected[$];
    int unsigned         errors;

    function new();
      foreach (live[i]) live[i] = 1'b0;
      now_tick = '0;
      errors   = 0;
    endfunction

    // first live slot holding the key, ENTRIES when there is none
    function int unsigned find_match(logic [KEY_BITS-1:0] key);
      for (int unsigned i = 0; i < ENTRIES; i++) begin
        if (live[i] && tags[i] == key) return i;
      end
      return ENTRIES;
    endfunction

    // lowest free slot, else the oldest stamp with the lowest index on a tie
    function int unsigned pick_victim();
      int unsigned        best;
      logic [STAMP_W-1:0] best_stamp;
      best       = 0;
      best_stamp = '1;
      for (int unsigned i = 0; i < ENTRIES; i++) begin
        if (!live[i]) return i;
        if (stamps[i] < best_stamp) begin
          best_stamp = stamps[i];
          best       = i;
        end
      end
      return best;
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key_in,
                               logic fill);
      logic [KEY_BITS-1:0] key;
      int unsigned         idx;
      int unsigned         count;
      result_t             res;
      key = key_in[KEY_BITS-1:0];
      res = '0;
      case (req)
        REQ_LOOKUP: begin
          idx = find_match(key);
          if (idx < ENTRIES) begin
            stamps[idx] = now_tick;
            res.status  = ST_HIT;
            res.slot    = SLOT_W'(idx);
          end else if (fill) begin
            idx         = pick_victim();
            res.evicted = live[idx];
            tags[idx]   = key;
            stamps[idx] = now_tick;
            live[idx]   = 1'b1;
            res.status  = ST_FILLED;
            res.slot    = SLOT_W'(idx);
          end else begin
            res.status = ST_MISS;
          end
        end
        REQ_PUT: begin
          idx = find_match(key);
          if (idx < ENTRIES) begin
            res.status = ST_PUT_OLD;
          end else begin
            idx         = pick_victim();
            res.evicted = live[idx];
            res.status  = ST_PUT_NEW;
          end
          tags[idx]   = key;
          stamps[idx] = now_tick;
          live[idx]   = 1'b1;
          res.slot    = SLOT_W'(idx);
        end
        REQ_TICK: begin
          now_tick   = now_tick + STAMP_W'(1);
          res.status = ST_TICK;
        end
        default: begin
          res.status = ST_MISS;
        end
      endcase
      count = 0;
      foreach (live[i]) count += live[i];
      res.occupied = OCC_W'(count);
      expected.push_back(res);
    endfunction

    function void flag(string field, int unsigned want, int unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                 $time, got.status, got.slot);
        return;
      end
      want = expected.pop_front();
      if (got.status !== want.status)     flag("status", want.status, got.status);
      if (got.slot !== want.slot)         flag("slot", want.slot, got.slot);
      if (got.evicted !== want.evicted)   flag("evicted", want.evicted, got.evicted);
      if (got.occupied !== want.occupied) flag("occupied", want.occupied, got.occupied);
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [REQ_W-1:0]    req_type_i  = REQ_LOOKUP;
  logic [KEY_W-1:0]    key_hash_i  = '0;
  logic                fill_ok_i   = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [SLOT_W-1:0]   slot_o;
  logic                evicted_o;
  logic [OCC_W-1:0]    occupied_o;

  lru_scoreboard       sb;
  bit                  gaps_on = 1'b1;
  logic [KEY_W-1:0]    key_pool[KEY_POOL_SIZE];

  lru_tag_store #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .key_hash_i  (key_hash_i),
    .fill_ok_i   (fill_ok_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .slot_o      (slot_o),
    .evicted_o   (evicted_o),
    .occupied_o  (occupied_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // drive one request: optional idle cycles, then hold it until accepted
  task automatic send_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key, logic fill);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    key_hash_i <= key;
    fill_ok_i  <= fill;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(req, key, fill);
  endtask

  // hold the request side quiet until every predicted result has come out
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // result side: check on each handshake, then choose the next ready value
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        sb.check_result('{status_o, slot_o, evicted_o, occupied_o});
      out_ready_i <= !(gaps_on && $urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("lru_tag_store_test: errors");
        $finish;
      end
    end
  end

  initial begin
    int unsigned pick;
    logic [REQ_W-1:0] req;
    logic [KEY_W-1:0] key;
    sb = new();
    foreach (key_pool[i]) key_pool[i] = random_key();
    key_pool[0] = '0;
    key_pool[1] = '1;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every request kind, miss with and without fill, hit, both
    // put outcomes, the unused type, and keys at the extremes
    send_request(REQ_LOOKUP, 64'h0, 1'b0);
    send_request(REQ_UNUSED, 64'h0, 1'b0);
    send_request(REQ_TICK,   64'h0, 1'b0);
    send_request(REQ_PUT,    64'h0, 1'b0);
    send_request(REQ_LOOKUP, '1, 1'b1);
    send_request(REQ_LOOKUP, '1, 1'b0);
    send_request(REQ_LOOKUP, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    send_request(REQ_PUT,    64'haaaa_aaaa_aaaa_aaaa, 1'b1);
    send_request(REQ_PUT,    64'h0, 1'b1);
    send_request(REQ_TICK,   '1, 1'b1);
    send_request(REQ_LOOKUP, 64'h5555_5555_5555_5555, 1'b1);
    send_request(REQ_LOOKUP, 64'h0, 1'b1);
    send_request(REQ_PUT,    64'h8000_0000_0000_0001, 1'b0);
    send_request(REQ_UNUSED, '1, 1'b1);
    send_request(REQ_TICK,   64'h0, 1'b0);
    wait_for_drain();

    // random traffic over a key pool larger than the store, so hits, fills
    // into free slots and lru evictions all show up
    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == 700) gaps_on = 1'b0;
      if (n == 1000) gaps_on = 1'b1;
      if (n == 400 || n == 1000) wait_for_drain();
      if ($urandom_range(0, 99) < 2)
        key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)] = random_key();
      pick = $urandom_range(0, 99);
      if (pick < 42)      req = REQ_LOOKUP;
      else if (pick < 70) req = REQ_PUT;
      else if (pick < 94) req = REQ_TICK;
      else                req = REQ_UNUSED;
      if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
      else                            key = random_key();
      send_request(req, key, $urandom_range(0, 99) < 70);
    end
    in_valid_i <= 1'b0;

    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected.size() == 0)
      $display("lru_tag_store_test: clean");
    else
      $display("lru_tag_store_test: errors");
    $finish;
  end

endmodule

/* lru_tag_store.f */
hdl/lts_pkg.sv
hdl/lts_scan_unit.sv
hdl/lru_tag_store.sv
dv/lru_tag_store_test.sv
